// ===== rtl/mi3_pkg.sv =====
// Shared types, widths and cofactor index tables for the 3x3 matrix inverse.
// Used by every module of the block; depends on nothing.
package mi3_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int NumEnt    = 9;
   localparam int ThrW      = 31;

   localparam int ProdW   = 2 * DataWidth;
   localparam int AdjW    = 2 * DataWidth + 1;
   localparam int AdjMagW = 2 * DataWidth;
   localparam int LoW     = DataWidth + 1;
   localparam int HiW     = AdjW - LoW;
   localparam int DetW    = 3 * DataWidth + 3;
   localparam int DmagW   = DetW - 1;
   localparam int NumW    = AdjMagW + 2 * FracBits;
   localparam int XW      = ((NumW + 1 > DmagW) ? NumW + 1 : DmagW) + 1;
   localparam int QuoW    = DataWidth + 1;
   localparam int RemW    = XW + 1;
   localparam int TdataW  = ((NumEnt * DataWidth + 7) / 8) * 8;

   localparam logic [QuoW-1:0] LimNeg = QuoW'(1) << (DataWidth - 1);
   localparam logic [QuoW-1:0] LimPos = LimNeg - QuoW'(1);

   // adj[k] = +-(e[a]*e[b] - e[c]*e[d])
   localparam int CofA [NumEnt] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
   localparam int CofB [NumEnt] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
   localparam int CofC [NumEnt] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
   localparam int CofD [NumEnt] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
   localparam bit CofNeg [NumEnt] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   typedef logic signed [DataWidth-1:0] ent_type;
   typedef logic signed [ProdW-1:0]     prod_type;
   typedef logic signed [AdjW-1:0]      adj_type;
   typedef logic signed [DetW-1:0]      det_type;
   typedef logic [XW-1:0]               x_type;

   typedef struct packed {
      logic              valid;
      logic              sing;
      logic [NumEnt-1:0] neg;
      logic [NumEnt-1:0] ovf;
   } ctl_type;

endpackage

// ===== rtl/mi3_adj.sv =====
// Cofactor stages: eighteen signed products, then signed differences (adjugate).
// Depends on mi3_pkg.
module mi3_adj (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  mi3_pkg::ent_type in_ent [mi3_pkg::NumEnt],
   output logic             out_valid,
   output mi3_pkg::adj_type out_adj [mi3_pkg::NumEnt],
   output mi3_pkg::ent_type out_row [3]
);
   import mi3_pkg::*;

   prod_type p_in [NumEnt];
   prod_type s_in [NumEnt];
   prod_type p_ff [NumEnt];
   prod_type s_ff [NumEnt];
   ent_type  row1_ff [3];
   logic     v1_ff;
   adj_type  adj_in [NumEnt];
   adj_type  adj_ff [NumEnt];
   ent_type  row2_ff [3];
   logic     v2_ff;

   always_comb begin
      for (int k = 0; k < NumEnt; k++) begin
         p_in[k] = in_ent[CofA[k]] * in_ent[CofB[k]];
         s_in[k] = in_ent[CofC[k]] * in_ent[CofD[k]];
      end
   end

   always_comb begin
      for (int k = 0; k < NumEnt; k++) begin
         if (CofNeg[k]) begin
            adj_in[k] = adj_type'(s_ff[k]) - adj_type'(p_ff[k]);
         end else begin
            adj_in[k] = adj_type'(p_ff[k]) - adj_type'(s_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in;
         s_ff    <= s_in;
         row1_ff <= in_ent[0:2];
         adj_ff  <= adj_in;
         row2_ff <= row1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_adj   = adj_ff;
   assign out_row   = row2_ff;

endmodule

// ===== rtl/mi3_det.sv =====
// Determinant stages: first-row expansion with split 32x33 / 32x32 partial products.
// Depends on mi3_pkg.
module mi3_det (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  mi3_pkg::adj_type in_adj [mi3_pkg::NumEnt],
   input  mi3_pkg::ent_type in_row [3],
   output logic             out_valid,
   output mi3_pkg::adj_type out_adj [mi3_pkg::NumEnt],
   output mi3_pkg::det_type out_det
);
   import mi3_pkg::*;

   typedef logic signed [DataWidth+LoW:0]   pl_type;
   typedef logic signed [DataWidth+HiW-1:0] ph_type;

   pl_type  pl_in [3];
   ph_type  ph_in [3];
   pl_type  pl_ff [3];
   ph_type  ph_ff [3];
   det_type t_in [3];
   det_type t_ff [3];
   det_type det_in;
   det_type det_ff;
   adj_type adj3_ff [NumEnt];
   adj_type adj4_ff [NumEnt];
   adj_type adj5_ff [NumEnt];
   logic    v3_ff;
   logic    v4_ff;
   logic    v5_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         pl_in[r] = in_row[r] * $signed({1'b0, in_adj[3*r][LoW-1:0]});
         ph_in[r] = in_row[r] * $signed(in_adj[3*r][AdjW-1:LoW]);
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         t_in[r] = (det_type'(ph_ff[r]) <<< LoW) + det_type'(pl_ff[r]);
      end
      det_in = t_ff[0] + t_ff[1] + t_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         adj3_ff <= in_adj;
         t_ff    <= t_in;
         adj4_ff <= adj3_ff;
         det_ff  <= det_in;
         adj5_ff <= adj4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_adj   = adj5_ff;
   assign out_det   = det_ff;

endmodule

// ===== rtl/mi3_prep.sv =====
// Divider setup: magnitudes, signs, singular test, rounded dividend and overflow check.
// Depends on mi3_pkg.
module mi3_prep (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  mi3_pkg::adj_type          in_adj [mi3_pkg::NumEnt],
   input  mi3_pkg::det_type          in_det,
   input  logic [mi3_pkg::ThrW-1:0]  thr,
   output mi3_pkg::ctl_type          out_ctl,
   output mi3_pkg::x_type            out_x [mi3_pkg::NumEnt],
   output mi3_pkg::x_type            out_y
);
   import mi3_pkg::*;

   logic [DmagW-1:0]      dmag_in;
   logic [DmagW-1:0]      dmag_ff;
   logic [AdjMagW-1:0]    amag_in [NumEnt];
   logic [AdjMagW-1:0]    amag_ff [NumEnt];
   logic [NumEnt-1:0]     neg_in;
   logic [NumEnt-1:0]     neg_ff;
   logic [ThrW+2*FracBits-1:0] thr_sh;
   logic                  sing_in;
   logic                  sing_ff;
   logic                  v6_ff;
   x_type                 x_in [NumEnt];
   x_type                 y_in;
   logic [NumEnt-1:0]     ovf_in;
   x_type                 x_ff [NumEnt];
   x_type                 y_ff;
   ctl_type               ctl_ff;

   always_comb begin
      dmag_in = in_det[DetW-1] ? DmagW'(-in_det) : DmagW'(in_det);
      for (int k = 0; k < NumEnt; k++) begin
         amag_in[k] = in_adj[k][AdjW-1] ? AdjMagW'(-in_adj[k]) : AdjMagW'(in_adj[k]);
         neg_in[k]  = in_adj[k][AdjW-1] ^ in_det[DetW-1];
      end
      thr_sh  = {thr, (2*FracBits)'(0)};
      // zero determinant is singular even with a zero threshold
      sing_in = (dmag_in == '0) || (dmag_in < thr_sh);
   end

   // dividend 2*|adj|*2^(2F) + |det| over 2*|det| rounds to nearest, ties away
   always_comb begin
      y_in = XW'({dmag_ff, 1'b0});
      for (int k = 0; k < NumEnt; k++) begin
         x_in[k]   = XW'({amag_ff[k], (2*FracBits+1)'(0)}) + XW'(dmag_ff);
         ovf_in[k] = (x_in[k][XW-1:QuoW] >= y_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff        <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         v6_ff        <= in_valid;
         ctl_ff.valid <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmag_ff     <= dmag_in;
         amag_ff     <= amag_in;
         neg_ff      <= neg_in;
         sing_ff     <= sing_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         ctl_ff.sing <= sing_ff;
         ctl_ff.neg  <= neg_ff;
         ctl_ff.ovf  <= ovf_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;

endmodule

// ===== rtl/mi3_div.sv =====
// Restoring divider, one quotient bit per stage for all nine entries, then
// sign, saturation and singular zeroing into the output register. Depends on mi3_pkg.
module mi3_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  mi3_pkg::ctl_type in_ctl,
   input  mi3_pkg::x_type   in_x [mi3_pkg::NumEnt],
   input  mi3_pkg::x_type   in_y,
   output logic             out_valid,
   output mi3_pkg::ent_type out_inv [mi3_pkg::NumEnt],
   output logic             out_sing
);
   import mi3_pkg::*;

   typedef logic [RemW-1:0] rem_type;
   typedef logic [QuoW-1:0] quo_type;

   rem_type src_rem [QuoW][NumEnt];
   quo_type src_lo  [QuoW][NumEnt];
   quo_type src_quo [QuoW][NumEnt];
   x_type   src_y   [QuoW];
   ctl_type src_ctl [QuoW];

   rem_type rem_ff [QuoW][NumEnt];
   quo_type lo_ff  [QuoW][NumEnt];
   quo_type quo_ff [QuoW][NumEnt];
   x_type   y_ff   [QuoW];
   ctl_type ctl_ff [QuoW];

   ent_type inv_in [NumEnt];
   ent_type inv_ff [NumEnt];
   logic    sing_ff;
   logic    valid_ff;

   for (genvar j = 0; j < QuoW; j++) begin : g_stage
      rem_type trial  [NumEnt];
      rem_type rem_in [NumEnt];
      quo_type lo_in  [NumEnt];
      quo_type quo_in [NumEnt];
      logic    ge     [NumEnt];

      if (j == 0) begin : g_first
         always_comb begin
            for (int k = 0; k < NumEnt; k++) begin
               src_rem[j][k] = RemW'(in_x[k][XW-1:QuoW]);
               src_lo[j][k]  = in_x[k][QuoW-1:0];
               src_quo[j][k] = '0;
            end
            src_y[j]   = in_y;
            src_ctl[j] = in_ctl;
         end
      end else begin : g_next
         always_comb begin
            src_rem[j] = rem_ff[j-1];
            src_lo[j]  = lo_ff[j-1];
            src_quo[j] = quo_ff[j-1];
            src_y[j]   = y_ff[j-1];
            src_ctl[j] = ctl_ff[j-1];
         end
      end

      always_comb begin
         for (int k = 0; k < NumEnt; k++) begin
            trial[k]  = {src_rem[j][k][RemW-2:0], src_lo[j][k][QuoW-1]};
            ge[k]     = (trial[k] >= RemW'(src_y[j]));
            rem_in[k] = ge[k] ? trial[k] - RemW'(src_y[j]) : trial[k];
            lo_in[k]  = {src_lo[j][k][QuoW-2:0], 1'b0};
            quo_in[k] = {src_quo[j][k][QuoW-2:0], ge[k]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[j].valid <= src_ctl[j].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j]      <= rem_in;
            lo_ff[j]       <= lo_in;
            quo_ff[j]      <= quo_in;
            y_ff[j]        <= src_y[j];
            ctl_ff[j].sing <= src_ctl[j].sing;
            ctl_ff[j].neg  <= src_ctl[j].neg;
            ctl_ff[j].ovf  <= src_ctl[j].ovf;
         end
      end
   end

   always_comb begin
      quo_type lim;
      quo_type mag;
      quo_type val;
      for (int k = 0; k < NumEnt; k++) begin
         lim = ctl_ff[QuoW-1].neg[k] ? LimNeg : LimPos;
         mag = (ctl_ff[QuoW-1].ovf[k] || (quo_ff[QuoW-1][k] > lim)) ? lim : quo_ff[QuoW-1][k];
         val = ctl_ff[QuoW-1].neg[k] ? -mag : mag;
         inv_in[k] = ctl_ff[QuoW-1].sing ? '0 : ent_type'(val[DataWidth-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= ctl_ff[QuoW-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         inv_ff  <= inv_in;
         sing_ff <= ctl_ff[QuoW-1].sing;
      end
   end

   assign out_valid = valid_ff;
   assign out_inv   = inv_ff;
   assign out_sing  = sing_ff;

endmodule

// ===== rtl/matrix_inverse_3x3_top.sv =====
// Pipeline registers from input transfer to rsp_tvalid, in order: 2 cofactor,
// 3 determinant, 2 setup, one per quotient bit, 1 output register.
// Throughput: one matrix per cycle; the whole pipeline holds while a result waits
// with rsp_tready low. Reset clears all valid bits and sets singular_threshold to 1.
// Top level of the 3x3 matrix inverse; depends on mi3_pkg and all mi3_* modules.
module matrix_inverse_3x3_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // a_r1c1, a_r1c2, a_r1c3, a_r2c1, ... a_r3c3 from bit 0 up, 32 bits each
   input  logic [mi3_pkg::TdataW-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // inv_r1c1, inv_r1c2, inv_r1c3, inv_r2c1, ... inv_r3c3 from bit 0 up, 32 bits each
   output logic [mi3_pkg::TdataW-1:0]   rsp_tdata,
   // singular
   output logic                         rsp_tuser,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mi3_pkg::ThrW-1:0]     csr_data
);
   import mi3_pkg::*;

   logic          adv;
   logic [ThrW-1:0] thr_ff;
   ent_type       in_ent [NumEnt];
   logic          adj_valid;
   adj_type       adj [NumEnt];
   ent_type       row [3];
   logic          det_valid;
   adj_type       det_adj [NumEnt];
   det_type       det;
   ctl_type       ctl;
   x_type         x [NumEnt];
   x_type         y;
   ent_type       inv [NumEnt];
   logic          sing;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThrW'(1);
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   always_comb begin
      for (int k = 0; k < NumEnt; k++) begin
         in_ent[k] = req_tdata[k*DataWidth +: DataWidth];
      end
   end

   mi3_adj u_adj (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_ent    (in_ent),
      .out_valid (adj_valid),
      .out_adj   (adj),
      .out_row   (row)
   );

   mi3_det u_det (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (adj_valid),
      .in_adj    (adj),
      .in_row    (row),
      .out_valid (det_valid),
      .out_adj   (det_adj),
      .out_det   (det)
   );

   mi3_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (det_valid),
      .in_adj   (det_adj),
      .in_det   (det),
      .thr      (thr_ff),
      .out_ctl  (ctl),
      .out_x    (x),
      .out_y    (y)
   );

   mi3_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_ctl    (ctl),
      .in_x      (x),
      .in_y      (y),
      .out_valid (rsp_tvalid),
      .out_inv   (inv),
      .out_sing  (sing)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < NumEnt; k++) begin
         rsp_tdata[k*DataWidth +: DataWidth] = inv[k];
      end
   end

   assign rsp_tuser = sing;

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("singular result carries nonzero entries");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_thr_reset: assert property (@(posedge clock)
      reset |=> thr_ff == ThrW'(1))
      else $error("threshold not restored by reset");

endmodule

// ===== tb/sv/tb_matrix_inverse_3x3_top.sv =====
// Self-checking testbench for the 3x3 matrix inverse: predicts each inverse
// with exact wide arithmetic and compares every result transfer. Needs mi3_pkg and the RTL.
`timescale 1ns / 1ps

class inverse_scoreboard;
   typedef logic signed [255:0] wide_t;
   typedef struct {
      logic [mi3_pkg::TdataW-1:0] inv;
      logic                       sing;
   } inverse_t;

   inverse_t expected_q[$];
   logic [30:0] threshold = 31'd1;
   int errors = 0;

   // Predict the inverse of one matrix and queue it.
   function void note_matrix(logic [mi3_pkg::TdataW-1:0] d);
      wide_t e[9];
      wide_t adj[9];
      wide_t det;
      logic [255:0] dabs, num, q, lim, th;
      logic det_neg, neg;
      inverse_t r;
      for (int k = 0; k < 9; k++) begin
         e[k] = {{224{d[k*32+31]}}, d[k*32 +: 32]};
      end
      adj[0] =   e[4] * e[8] - e[5] * e[7];
      adj[1] = -(e[1] * e[8] - e[2] * e[7]);
      adj[2] =   e[1] * e[5] - e[2] * e[4];
      adj[3] = -(e[3] * e[8] - e[5] * e[6]);
      adj[4] =   e[0] * e[8] - e[2] * e[6];
      adj[5] = -(e[0] * e[5] - e[2] * e[3]);
      adj[6] =   e[3] * e[7] - e[4] * e[6];
      adj[7] = -(e[0] * e[7] - e[1] * e[6]);
      adj[8] =   e[0] * e[4] - e[1] * e[3];
      det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
      det_neg = det[255];
      dabs = det_neg ? -det : det;
      th = {225'd0, threshold} << 32;
      r.inv = '0;
      r.sing = 1'b0;
      if (dabs == 0 || dabs < th) begin
         r.sing = 1'b1;
      end else begin
         for (int k = 0; k < 9; k++) begin
            num = adj[k][255] ? -adj[k] : adj[k];
            num = (num << 33) + dabs;
            q = num / (dabs << 1);
            neg = adj[k][255] != det_neg;
            lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
            if (q > lim) q = lim;
            r.inv[k*32 +: 32] = neg ? -q[31:0] : q[31:0];
         end
      end
      expected_q.push_back(r);
   endfunction

   function void check_result(logic [mi3_pkg::TdataW-1:0] d, logic sing);
      inverse_t x;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result %h sing %b", $time, d, sing);
         errors++;
         return;
      end
      x = expected_q.pop_front();
      if (sing !== x.sing) begin
         $display("%0t: singular exp %b act %b", $time, x.sing, sing);
         errors++;
      end
      for (int k = 0; k < 9; k++) begin
         if (d[k*32 +: 32] !== x.inv[k*32 +: 32]) begin
            $display("%0t: entry %0d exp %h act %h", $time, k,
                     x.inv[k*32 +: 32], d[k*32 +: 32]);
            errors++;
         end
      end
   endfunction
endclass

module tb_matrix_inverse_3x3_top;
   import mi3_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [TdataW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [TdataW-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [ThrW-1:0] csr_data = '0;

   inverse_scoreboard inv_sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   localparam int WatchdogLimit = 4000;
   localparam int One = 32'h0001_0000;

   matrix_inverse_3x3_top uut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Sample transfers before this edge's updates land.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) inv_sb.note_matrix(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) inv_sb.check_result(rsp_tdata, rsp_tuser);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_matrix(input logic [TdataW-1:0] m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= m;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_threshold(input logic [ThrW-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      inv_sb.threshold = v;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (inv_sb.expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [TdataW-1:0] pack9(input logic [31:0] v[9]);
      logic [TdataW-1:0] m;
      m = '0;
      for (int k = 0; k < 9; k++) m[k*32 +: 32] = v[k];
      return m;
   endfunction

   function automatic logic [31:0] small_entry();
      return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
   endfunction

   function automatic logic [TdataW-1:0] random_matrix();
      logic [31:0] v[9];
      int kind;
      kind = $urandom_range(9);
      for (int k = 0; k < 9; k++) v[k] = (kind < 3) ? $urandom() : small_entry();
      if (kind == 3) begin
         // dependent third row: singular or nearly so
         for (int k = 0; k < 3; k++) v[6+k] = v[k] + v[3+k] + $urandom_range(1);
      end else if (kind == 4) begin
         for (int k = 0; k < 9; k++) v[k] = (k % 4 == 0) ? $urandom() : $urandom_range(3);
      end else if (kind == 5 && $urandom_range(3) == 0) begin
         for (int k = 0; k < 3; k++) v[3+k] = 0;
      end
      return pack9(v);
   endfunction

   initial begin
      logic [31:0] v[9];
      logic [ThrW-1:0] thr_list[8];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cases at the reset threshold
      foreach (v[k]) v[k] = (k % 4 == 0) ? One : 0;
      send_matrix(pack9(v));
      foreach (v[k]) v[k] = 0;
      send_matrix(pack9(v));
      foreach (v[k]) v[k] = 32'h7FFF_FFFF;
      send_matrix(pack9(v));
      foreach (v[k]) v[k] = 32'h8000_0000;
      send_matrix(pack9(v));
      foreach (v[k]) v[k] = (k % 4 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      send_matrix(pack9(v));
      foreach (v[k]) v[k] = (k % 4 == 0) ? 32'd1 : 0;
      send_matrix(pack9(v));
      foreach (v[k]) v[k] = (k % 4 == 0) ? -32'd1 : 0;
      send_matrix(pack9(v));
      foreach (v[k]) v[k] = (k % 4 == 0) ? 32'h7FFF_FFFF : 0;
      send_matrix(pack9(v));
      foreach (v[k]) v[k] = (k % 4 == 0) ? 32'h8000_0000 : 0;
      send_matrix(pack9(v));
      // det just at and below the reset threshold (2^-16)
      foreach (v[k]) v[k] = 0;
      v[0] = 32'd256; v[4] = 32'd256; v[8] = One;
      send_matrix(pack9(v));
      v[0] = 32'd255;
      send_matrix(pack9(v));
      v[0] = 32'd3 * One; v[1] = 32'd2 * One; v[3] = -32'd1 * One;
      v[4] = 32'd5 * One; v[5] = 32'd7; v[7] = -32'd4 * One; v[8] = One / 2;
      send_matrix(pack9(v));
      foreach (v[k]) v[k] = k + 1;
      send_matrix(pack9(v));
      for (int n = 0; n < 8; n++) send_matrix(random_matrix());
      drain();

      thr_list = '{31'd0, 31'h7FFF_FFFF, 31'(One), 31'($urandom()), 31'd1, 31'd0,
                   31'($urandom_range(1 << 20)), 31'd5};
      for (int p = 0; p < 8; p++) begin
         write_threshold(thr_list[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         if (p == 4) hold_cycles = 300;
         for (int n = 0; n < 141; n++) send_matrix(random_matrix());
         drain();
      end

      if (inv_sb.errors == 0 && inv_sb.expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/mi3_pkg.sv
rtl/mi3_adj.sv
rtl/mi3_det.sv
rtl/mi3_prep.sv
rtl/mi3_div.sv
rtl/matrix_inverse_3x3_top.sv
tb/sv/tb_matrix_inverse_3x3_top.sv
